FILE: hdl/aoi_pkg.sv
// Shared types, codes and constants of the area-of-interest tracker.
// No dependencies; every other file of the block but aoi_ram imports this package.
package aoi_pkg;

  localparam int DEF_MAX_ENTITIES = 64;
  localparam int DEF_COORD_BITS   = 16;

  localparam int ID_W        = 6;
  localparam int POS_W       = 16;
  localparam int RADIUS_W    = 16;
  localparam int GRID_W      = 13;
  localparam int LIM_W       = GRID_W + RADIUS_W;
  localparam int SQ_W        = 2 * RADIUS_W;
  localparam int KIND_W      = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VIEW_RADIUS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLUMNS    = 2'd2;

  localparam logic [RADIUS_W-1:0] RESET_MAX_VIEW_RADIUS = 16'd100;
  localparam logic [GRID_W-1:0]   RESET_GRID_ROWS       = 13'd16;
  localparam logic [GRID_W-1:0]   RESET_GRID_COLUMNS    = 13'd16;

  // Command modes.
  localparam logic [1:0] MODE_ENTER = 2'd0;
  localparam logic [1:0] MODE_LEAVE = 2'd1;
  localparam logic [1:0] MODE_MOVE  = 2'd2;

  // Notice kinds.
  localparam logic [KIND_W-1:0] EV_ENTER = 2'd0;
  localparam logic [KIND_W-1:0] EV_LEAVE = 2'd1;
  localparam logic [KIND_W-1:0] EV_MOVE  = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [ID_W-1:0]     entity_id;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [RADIUS_W-1:0] view_radius;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [ID_W-1:0]   watcher_id;
    logic [ID_W-1:0]   mover_id;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SPAN,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_FLUSH
  } state_t;

endpackage

FILE: hdl/area_of_interest_tracker_top.sv
// Area-of-interest tracker: entity table in one RAM, slot scan with two test pipes.
// One command at a time: busy until the command is done, for a time set by the
// bit-serial cell remainder and the one-slot-per-cycle scan. The last notice is on
// the ports in the first cycle with busy low; the receiver cannot stall notices.
// Synchronous reset empties every slot and restores the register defaults. Uses
// aoi_pkg, aoi_ram, aoi_span and aoi_sees.
module area_of_interest_tracker_top import aoi_pkg::*; #(
  parameter int MAX_ENTITIES = DEF_MAX_ENTITIES,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               item,
  output logic                   result_strobe,
  output out_item_t              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDW = $clog2(MAX_ENTITIES);
  localparam int CB  = COORD_BITS;
  localparam int BW  = ((CB > RADIUS_W + 1) ? CB : RADIUS_W + 1) + 1;
  localparam int WW  = 2 * CB + RADIUS_W;

  state_t state;
  state_t state_next;

  logic [RADIUS_W-1:0] max_view_radius;
  logic [GRID_W-1:0]   grid_rows;
  logic [GRID_W-1:0]   grid_columns;
  logic [RADIUS_W-1:0] side;
  logic [LIM_W-1:0]    x_limit;
  logic [LIM_W-1:0]    y_limit;

  logic [1:0]          mode_q;
  logic [ID_W-1:0]     id_q;
  logic [CB-1:0]       nx;
  logic [CB-1:0]       ny;
  logic [RADIUS_W-1:0] nrad;
  logic [CB-1:0]       ox;
  logic [CB-1:0]       oy;
  logic [RADIUS_W-1:0] orad;
  logic [RADIUS_W-1:0] rnow;
  logic [SQ_W-1:0]     r_was_sq;
  logic [SQ_W-1:0]     r_now_sq;

  logic [MAX_ENTITIES-1:0] slot_valid;

  logic            ram_we;
  logic [IDW-1:0]  ram_raddr;
  logic [WW-1:0]   ram_wdata;
  logic [WW-1:0]   ram_rdata;
  logic [CB-1:0]   rd_x;
  logic [CB-1:0]   rd_y;
  logic [RADIUS_W-1:0] rd_rad;

  logic            span_start;
  logic            span_done;
  logic            span_old_done;
  logic [BW-1:0]   old_x_lo, old_x_hi, old_y_lo, old_y_hi;
  logic [BW-1:0]   new_x_lo, new_x_hi, new_y_lo, new_y_hi;

  logic [IDW-1:0]  j;
  logic [IDW-1:0]  j1, j2, j3;
  logic            p1, p2, p3;
  logic            slot_ok;
  logic            hit_was;
  logic            hit_now;
  logic [KIND_W-1:0] hit_kind;

  logic              pend_valid;
  logic [KIND_W-1:0] pend_kind;
  logic [IDW-1:0]    pend_watcher;

  logic            id_ok;
  logic            mode_ok;
  logic            drop_fetch;
  logic            in_grid;
  logic            drop_check;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_view_radius <= RESET_MAX_VIEW_RADIUS;
      grid_rows       <= RESET_GRID_ROWS;
      grid_columns    <= RESET_GRID_COLUMNS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_VIEW_RADIUS: max_view_radius <= cfg_data;
        CFG_GRID_ROWS:       grid_rows       <= cfg_data[GRID_W-1:0];
        CFG_GRID_COLUMNS:    grid_columns    <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero cell side behaves as one.
  assign side = (max_view_radius == '0) ? RADIUS_W'(1) : max_view_radius;

  always_ff @(posedge clk) begin
    x_limit <= LIM_W'(grid_columns) * LIM_W'(side);
    y_limit <= LIM_W'(grid_rows) * LIM_W'(side);
  end

  assign rd_x   = ram_rdata[WW-1 -: CB];
  assign rd_y   = ram_rdata[WW-CB-1 -: CB];
  assign rd_rad = ram_rdata[RADIUS_W-1:0];

  assign id_ok   = {1'b0, id_q} < (ID_W + 1)'(MAX_ENTITIES);
  assign mode_ok = (mode_q == MODE_ENTER) || (mode_q == MODE_LEAVE) || (mode_q == MODE_MOVE);
  assign drop_fetch = !mode_ok || !id_ok ||
                      ((mode_q != MODE_ENTER) && !slot_valid[id_q[IDW-1:0]]);
  assign in_grid = (32'(nx) < 32'(x_limit)) && (32'(ny) < 32'(y_limit));
  // A leave ignores the position fields.
  assign drop_check = ((mode_q != MODE_LEAVE) && !in_grid) ||
                      ((mode_q == MODE_ENTER) && (nrad > side));

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    span_start = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = j;
    unique case (state)
      S_IDLE: begin
        ram_raddr = item.entity_id[IDW-1:0];
        if (start) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (drop_fetch) begin
          state_next = S_IDLE;
        end else begin
          span_start = 1'b1;
          state_next = S_SPAN;
        end
      end
      S_SPAN: begin
        if (span_done && span_old_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = drop_check ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        if (j == IDW'(MAX_ENTITIES - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!(p1 || p2 || p3)) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        ram_we     = (mode_q == MODE_ENTER) || (mode_q == MODE_MOVE);
        state_next = S_IDLE;
      end
    endcase
  end

  // Command and actor registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      mode_q <= item.mode;
      id_q   <= item.entity_id;
      nx     <= CB'(item.pos_x);
      ny     <= CB'(item.pos_y);
      nrad   <= item.view_radius;
    end
    if (state == S_FETCH) begin
      ox   <= rd_x;
      oy   <= rd_y;
      orad <= rd_rad;
    end
    r_was_sq <= SQ_W'(orad) * SQ_W'(orad);
    r_now_sq <= SQ_W'(rnow) * SQ_W'(rnow);
    j1 <= j;
    j2 <= j1;
    j3 <= j2;
  end

  assign rnow = (mode_q == MODE_ENTER) ? nrad : orad;

  always_ff @(posedge clk) begin
    if (rst) begin
      j  <= '0;
      p1 <= 1'b0;
      p2 <= 1'b0;
      p3 <= 1'b0;
    end else begin
      if (state == S_CHECK) begin
        j <= '0;
      end else if (state == S_SCAN) begin
        j <= j + IDW'(1);
      end
      p1 <= (state == S_SCAN);
      p2 <= p1;
      p3 <= p2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (state == S_FLUSH) begin
      if (mode_q == MODE_ENTER) begin
        slot_valid[id_q[IDW-1:0]] <= 1'b1;
      end else if (mode_q == MODE_LEAVE) begin
        slot_valid[id_q[IDW-1:0]] <= 1'b0;
      end
    end
  end

  assign ram_wdata = {nx, ny, rnow};

  aoi_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_ENTITIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (id_q[IDW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  aoi_span #(.COORD_BITS(CB)) u_span_old (
    .clk   (clk),
    .rst   (rst),
    .start (span_start),
    .side  (side),
    .ax    (rd_x),
    .ay    (rd_y),
    .done  (span_old_done),
    .x_lo  (old_x_lo),
    .x_hi  (old_x_hi),
    .y_lo  (old_y_lo),
    .y_hi  (old_y_hi)
  );

  aoi_span #(.COORD_BITS(CB)) u_span_new (
    .clk   (clk),
    .rst   (rst),
    .start (span_start),
    .side  (side),
    .ax    (nx),
    .ay    (ny),
    .done  (span_done),
    .x_lo  (new_x_lo),
    .x_hi  (new_x_hi),
    .y_lo  (new_y_lo),
    .y_hi  (new_y_hi)
  );

  assign slot_ok = slot_valid[j1] && (j1 != id_q[IDW-1:0]);

  aoi_sees #(.COORD_BITS(CB)) u_sees_was (
    .clk     (clk),
    .rst     (rst),
    .en      (mode_q != MODE_ENTER),
    .ax      (ox),
    .ay      (oy),
    .x_lo    (old_x_lo),
    .x_hi    (old_x_hi),
    .y_lo    (old_y_lo),
    .y_hi    (old_y_hi),
    .r_sq    (r_was_sq),
    .slot_ok (slot_ok),
    .bx      (rd_x),
    .by      (rd_y),
    .hit     (hit_was)
  );

  aoi_sees #(.COORD_BITS(CB)) u_sees_now (
    .clk     (clk),
    .rst     (rst),
    .en      (mode_q != MODE_LEAVE),
    .ax      (nx),
    .ay      (ny),
    .x_lo    (new_x_lo),
    .x_hi    (new_x_hi),
    .y_lo    (new_y_lo),
    .y_hi    (new_y_hi),
    .r_sq    (r_now_sq),
    .slot_ok (slot_ok),
    .bx      (rd_x),
    .by      (rd_y),
    .hit     (hit_now)
  );

  always_comb begin
    priority if (hit_was && hit_now) begin
      hit_kind = EV_MOVE;
    end else if (hit_was) begin
      hit_kind = EV_LEAVE;
    end else begin
      hit_kind = EV_ENTER;
    end
  end

  // One notice is held back so that the final transfer of a command can carry last.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (p3 && (hit_was || hit_now)) begin
        result_strobe <= pend_valid;
        pend_valid    <= 1'b1;
      end else if (state == S_FLUSH) begin
        result_strobe <= pend_valid;
        pend_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p3 && (hit_was || hit_now)) begin
      result.event_kind <= pend_kind;
      result.watcher_id <= ID_W'(pend_watcher);
      result.mover_id   <= id_q;
      result.last       <= 1'b0;
      pend_kind         <= hit_kind;
      pend_watcher      <= j3;
    end else if (state == S_FLUSH) begin
      result.event_kind <= pend_kind;
      result.watcher_id <= ID_W'(pend_watcher);
      result.mover_id   <= id_q;
      result.last       <= 1'b1;
    end
  end

endmodule

FILE: hdl/aoi_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module aoi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/aoi_span.sv
// Cell span of one position: a restoring remainder by the cell side, one bit per
// cycle on both axes, then the coordinate range of the 3x3 cell block. Uses aoi_pkg.
module aoi_span import aoi_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [RADIUS_W-1:0]   side,
  input  logic [COORD_BITS-1:0] ax,
  input  logic [COORD_BITS-1:0] ay,
  output logic                  done,
  output logic [((COORD_BITS > RADIUS_W + 1) ? COORD_BITS : RADIUS_W + 1):0] x_lo,
  output logic [((COORD_BITS > RADIUS_W + 1) ? COORD_BITS : RADIUS_W + 1):0] x_hi,
  output logic [((COORD_BITS > RADIUS_W + 1) ? COORD_BITS : RADIUS_W + 1):0] y_lo,
  output logic [((COORD_BITS > RADIUS_W + 1) ? COORD_BITS : RADIUS_W + 1):0] y_hi
);

  localparam int CB    = COORD_BITS;
  localparam int BW    = ((CB > RADIUS_W + 1) ? CB : RADIUS_W + 1) + 1;
  localparam int CNT_W = $clog2(CB + 1);

  logic [CB-1:0]       a_q  [2];
  logic [CB-1:0]       sh   [2];
  logic [RADIUS_W-1:0] rem  [2];
  logic [RADIUS_W:0]   t    [2];
  logic [CB-1:0]       base [2];
  logic [BW-1:0]       lo   [2];
  logic [BW-1:0]       hi   [2];
  logic                running;
  logic                fin;
  logic [CNT_W-1:0]    cnt;

  // Cells a and b are within one step when b lies in [(ca-1)*side, (ca+2)*side).
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t[l]    = {rem[l], sh[l][CB-1]};
      base[l] = a_q[l] - CB'(rem[l]);
      if (BW'(base[l]) >= BW'(side)) begin
        lo[l] = BW'(base[l]) - BW'(side);
      end else begin
        lo[l] = '0;
      end
      hi[l] = BW'(base[l]) + (BW'(side) << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(CB);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q[0] <= ax;
      a_q[1] <= ay;
      sh[0]  <= ax;
      sh[1]  <= ay;
      rem[0] <= '0;
      rem[1] <= '0;
    end else if (running) begin
      for (int l = 0; l < 2; l++) begin
        sh[l] <= sh[l] << 1;
        if (t[l] >= {1'b0, side}) begin
          rem[l] <= RADIUS_W'(t[l] - {1'b0, side});
        end else begin
          rem[l] <= t[l][RADIUS_W-1:0];
        end
      end
    end
    if (fin) begin
      x_lo <= lo[0];
      x_hi <= hi[0];
      y_lo <= lo[1];
      y_hi <= hi[1];
    end
  end

endmodule

FILE: hdl/aoi_sees.sv
// Neighbor test pipeline for one actor position: cell range and distance check
// of the slot read from the table, two register stages. Uses aoi_pkg.
module aoi_sees import aoi_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [COORD_BITS-1:0] ax,
  input  logic [COORD_BITS-1:0] ay,
  input  logic [((COORD_BITS > RADIUS_W + 1) ? COORD_BITS : RADIUS_W + 1):0] x_lo,
  input  logic [((COORD_BITS > RADIUS_W + 1) ? COORD_BITS : RADIUS_W + 1):0] x_hi,
  input  logic [((COORD_BITS > RADIUS_W + 1) ? COORD_BITS : RADIUS_W + 1):0] y_lo,
  input  logic [((COORD_BITS > RADIUS_W + 1) ? COORD_BITS : RADIUS_W + 1):0] y_hi,
  input  logic [SQ_W-1:0]       r_sq,
  input  logic                  slot_ok,
  input  logic [COORD_BITS-1:0] bx,
  input  logic [COORD_BITS-1:0] by,
  output logic                  hit
);

  localparam int CB = COORD_BITS;
  localparam int BW = ((CB > RADIUS_W + 1) ? CB : RADIUS_W + 1) + 1;
  localparam int DW = (CB > RADIUS_W) ? CB : RADIUS_W;

  logic [BW-1:0]       bxe;
  logic [BW-1:0]       bye;
  logic                in_x;
  logic                in_y;
  logic [CB-1:0]       dx;
  logic [CB-1:0]       dy;
  logic [DW-1:0]       dxe;
  logic [DW-1:0]       dye;
  logic                far_x;
  logic                far_y;
  logic                ok_a;
  logic [RADIUS_W-1:0] dx16;
  logic [RADIUS_W-1:0] dy16;
  logic                ok_b;
  logic [SQ_W-1:0]     dxsq;
  logic [SQ_W-1:0]     dysq;

  always_comb begin
    bxe  = BW'(bx);
    bye  = BW'(by);
    in_x = (bxe >= x_lo) && (bxe < x_hi);
    in_y = (bye >= y_lo) && (bye < y_hi);
    dx   = (ax > bx) ? ax - bx : bx - ax;
    dy   = (ay > by) ? ay - by : by - ay;
    dxe  = DW'(dx);
    dye  = DW'(dy);
    // A radius never exceeds the radius field, so a longer axis distance fails.
    far_x = (dxe >> RADIUS_W) != '0;
    far_y = (dye >> RADIUS_W) != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ok_a <= 1'b0;
      ok_b <= 1'b0;
    end else begin
      ok_a <= en && slot_ok && in_x && in_y && !far_x && !far_y;
      ok_b <= ok_a;
    end
  end

  always_ff @(posedge clk) begin
    dx16 <= dxe[RADIUS_W-1:0];
    dy16 <= dye[RADIUS_W-1:0];
    dxsq <= SQ_W'(dx16) * SQ_W'(dx16);
    dysq <= SQ_W'(dy16) * SQ_W'(dy16);
  end

  assign hit = ok_b && (({1'b0, dxsq} + {1'b0, dysq}) <= {1'b0, r_sq});

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the area-of-interest tracker: directed commands, a crowded
// table and randomized phases under several grid settings, checked notice by notice.
// Depends on aoi_pkg and area_of_interest_tracker_top.
module testbench import aoi_pkg::*; ();

  class notice_scoreboard;
    logic [RADIUS_W-1:0] view_limit;
    logic [GRID_W-1:0]   row_count;
    logic [GRID_W-1:0]   column_count;
    bit                  slot_live [DEF_MAX_ENTITIES];
    logic [POS_W-1:0]    slot_px [DEF_MAX_ENTITIES];
    logic [POS_W-1:0]    slot_py [DEF_MAX_ENTITIES];
    logic [RADIUS_W-1:0] slot_rad [DEF_MAX_ENTITIES];
    out_item_t           notice_queue [$];
    int                  errors;

    function new();
      view_limit   = RESET_MAX_VIEW_RADIUS;
      row_count    = RESET_GRID_ROWS;
      column_count = RESET_GRID_COLUMNS;
      errors       = 0;
      foreach (slot_live[j]) slot_live[j] = 1'b0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_MAX_VIEW_RADIUS: view_limit = data;
        CFG_GRID_ROWS:       row_count = data[GRID_W-1:0];
        CFG_GRID_COLUMNS:    column_count = data[GRID_W-1:0];
        default: ;
      endcase
    endfunction

    // A cell side of zero behaves as one everywhere.
    function int unsigned cell_side();
      if (view_limit == '0) return 1;
      return {16'd0, view_limit};
    endfunction

    function longint unsigned grid_width();
      return 64'(column_count) * 64'(cell_side());
    endfunction

    function longint unsigned grid_height();
      return 64'(row_count) * 64'(cell_side());
    endfunction

    function bit in_grid(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
      return 64'(x) < grid_width() && 64'(y) < grid_height();
    endfunction

    function bit near_cell(logic [POS_W-1:0] a, logic [POS_W-1:0] b, int unsigned side);
      int unsigned ca, cb;
      ca = 32'(a) / side;
      cb = 32'(b) / side;
      return ((ca > cb) ? ca - cb : cb - ca) <= 1;
    endfunction

    // True when an actor in slot self at (x, y) with radius r sees slot j.
    function bit sees(int self, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                      logic [RADIUS_W-1:0] r, int j);
      longint unsigned dx, dy;
      int unsigned     side;
      side = cell_side();
      if (j == self || !slot_live[j]) return 1'b0;
      if (!near_cell(x, slot_px[j], side) || !near_cell(y, slot_py[j], side)) return 1'b0;
      dx = (x > slot_px[j]) ? 64'(x - slot_px[j]) : 64'(slot_px[j] - x);
      dy = (y > slot_py[j]) ? 64'(y - slot_py[j]) : 64'(slot_py[j] - y);
      return dx * dx + dy * dy <= 64'(r) * 64'(r);
    endfunction

    function out_item_t make_notice(logic [KIND_W-1:0] kind, int watcher, int mover);
      out_item_t n;
      n.event_kind = kind;
      n.watcher_id = ID_W'(watcher);
      n.mover_id   = ID_W'(mover);
      n.last       = 1'b0;
      return n;
    endfunction

    function void note_command(in_item_t cmd);
      out_item_t found [$];
      int        id;
      bit        was_seen, now_seen;
      id = int'(cmd.entity_id);
      case (cmd.mode)
        MODE_ENTER: begin
          if (32'(cmd.view_radius) <= cell_side() && in_grid(cmd.pos_x, cmd.pos_y)) begin
            slot_live[id] = 1'b1;
            slot_px[id]   = cmd.pos_x;
            slot_py[id]   = cmd.pos_y;
            slot_rad[id]  = cmd.view_radius;
            for (int j = 0; j < DEF_MAX_ENTITIES; j++)
              if (sees(id, cmd.pos_x, cmd.pos_y, cmd.view_radius, j))
                found = {found, make_notice(EV_ENTER, j, id)};
          end
        end
        MODE_LEAVE: begin
          if (slot_live[id]) begin
            for (int j = 0; j < DEF_MAX_ENTITIES; j++)
              if (sees(id, slot_px[id], slot_py[id], slot_rad[id], j))
                found = {found, make_notice(EV_LEAVE, j, id)};
            slot_live[id] = 1'b0;
          end
        end
        MODE_MOVE: begin
          if (slot_live[id] && in_grid(cmd.pos_x, cmd.pos_y)) begin
            for (int j = 0; j < DEF_MAX_ENTITIES; j++) begin
              was_seen = sees(id, slot_px[id], slot_py[id], slot_rad[id], j);
              now_seen = sees(id, cmd.pos_x, cmd.pos_y, slot_rad[id], j);
              if (was_seen && now_seen) found = {found, make_notice(EV_MOVE, j, id)};
              else if (was_seen) found = {found, make_notice(EV_LEAVE, j, id)};
              else if (now_seen) found = {found, make_notice(EV_ENTER, j, id)};
            end
            slot_px[id] = cmd.pos_x;
            slot_py[id] = cmd.pos_y;
          end
        end
        default: ;
      endcase
      if (found.size() != 0) found[found.size() - 1].last = 1'b1;
      notice_queue = {notice_queue, found};
    endfunction

    function void check_notice(out_item_t got);
      out_item_t want;
      if (notice_queue.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected notice kind %0d watcher %0d mover %0d last %0d", $time,
                   got.event_kind, got.watcher_id, got.mover_id, got.last);
        return;
      end
      want = notice_queue.pop_front();
      if (got.event_kind !== want.event_kind || got.watcher_id !== want.watcher_id ||
          got.mover_id !== want.mover_id || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: notice mismatch, expected kind %0d watcher %0d mover %0d last %0d,",
                   $time, want.event_kind, want.watcher_id, want.mover_id, want.last,
                   " got %0d %0d %0d %0d",
                   got.event_kind, got.watcher_id, got.mover_id, got.last);
      end
    endfunction

    function int pending();
      return notice_queue.size();
    endfunction

    // Picks an occupied slot when asked and one exists, otherwise any slot.
    function logic [ID_W-1:0] pick_slot(bit live_only);
      int live [$];
      foreach (slot_live[j]) if (slot_live[j]) live = {live, j};
      if (live_only && live.size() != 0)
        return ID_W'(live[$urandom_range(0, live.size() - 1)]);
      return ID_W'($urandom_range(0, DEF_MAX_ENTITIES - 1));
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 100;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASES        = 7;
  localparam logic [1:0] MODE_NONE = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  in_item_t               item = '0;
  logic                   result_strobe;
  out_item_t              result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_MAX_VIEW_RADIUS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  notice_scoreboard sb;
  int               quiet_cycles = 0;
  bit               steady = 1'b0;
  int unsigned      base_x, base_y, span_x, span_y;
  in_item_t         opening [$];

  // Grid settings per random phase; the first one also fills the table to capacity.
  int unsigned phase_side  [PHASES] = '{20, 65535, 1, 0, 50, 37, 100};
  int unsigned phase_rows  [PHASES] = '{4, 1, 4096, 65535, 0, 3, 16};
  int unsigned phase_cols  [PHASES] = '{4, 1, 4096, 65535, 9, 5, 16};
  int unsigned phase_items [PHASES] = '{25, 30, 30, 25, 8, 34, 40};

  area_of_interest_tracker_top u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_strobe(result_strobe),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (result_strobe) sb.check_notice(result);
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_command(item);
      if (result_strobe || cfg_we || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  function automatic in_item_t make_command(logic [1:0] mode, int id, int x, int y, int r);
    in_item_t c;
    c.mode        = mode;
    c.entity_id   = ID_W'(id);
    c.pos_x       = POS_W'(x);
    c.pos_y       = POS_W'(y);
    c.view_radius = RADIUS_W'(r);
    return c;
  endfunction

  function automatic void aim_axis(input longint unsigned ext, output int unsigned base,
                                   output int unsigned span);
    longint unsigned reach;
    reach = 64'(sb.cell_side()) * 3;
    if (ext > 65536) ext = 65536;
    if (ext == 0) begin
      base = 0;
      span = 65536;
    end else begin
      span = 32'((ext < reach) ? ext : reach);
      base = $urandom_range(0, 32'(ext) - span);
    end
  endfunction

  // Positions cluster within about three cells so that most commands have neighbors.
  function automatic void aim_cluster();
    aim_axis(sb.grid_width(), base_x, span_x);
    aim_axis(sb.grid_height(), base_y, span_y);
  endfunction

  function automatic in_item_t random_command();
    in_item_t    c;
    int unsigned side, roll;
    side          = sb.cell_side();
    roll          = $urandom_range(0, 99);
    c.mode        = MODE_MOVE;
    c.entity_id   = sb.pick_slot(1'b1);
    c.pos_x       = POS_W'(base_x + $urandom_range(0, span_x - 1));
    c.pos_y       = POS_W'(base_y + $urandom_range(0, span_y - 1));
    c.view_radius = RADIUS_W'($urandom_range(0, side));
    if (roll < 40) begin
      c.mode      = MODE_ENTER;
      c.entity_id = ID_W'($urandom_range(0, DEF_MAX_ENTITIES - 1));
      if ($urandom_range(0, 5) == 0) c.view_radius = RADIUS_W'(side);
    end else if (roll < 58) begin
      c.mode = MODE_LEAVE;
    end else if (roll < 90) begin
      c.mode = MODE_MOVE;
    end else if (roll < 93) begin
      // Enter that must be dropped: radius over the limit, or off the grid.
      c.mode = MODE_ENTER;
      if (side < 65535) c.view_radius = RADIUS_W'($urandom_range(side + 1, 65535));
      else c.pos_x = '1;
    end else if (roll < 97) begin
      c.mode        = 2'($urandom_range(0, 3));
      c.entity_id   = ID_W'($urandom_range(0, DEF_MAX_ENTITIES - 1));
      c.pos_x       = POS_W'($urandom);
      c.pos_y       = POS_W'($urandom);
      c.view_radius = RADIUS_W'($urandom);
    end else if (roll == 97) begin
      c.mode = MODE_NONE;
    end else begin
      c.mode      = roll[0] ? MODE_MOVE : MODE_LEAVE;
      c.entity_id = sb.pick_slot(1'b0);
    end
    return c;
  endfunction

  task automatic issue(input in_item_t cmd);
    @(negedge clk);
    start = 1'b1;
    item  = cmd;
    do @(posedge clk); while (busy);
  endtask

  task automatic sender_gap();
    int n;
    if (!steady && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 10);
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Registers change only once the block has drained, with no notices pending and
  // busy low, and after the extra settle time.
  task automatic program_registers(input int unsigned side, input int unsigned rows,
                                   input int unsigned cols);
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(CFG_MAX_VIEW_RADIUS, CFG_DATA_W'(side));
    write_register(CFG_GRID_ROWS, CFG_DATA_W'(rows));
    write_register(CFG_GRID_COLUMNS, CFG_DATA_W'(cols));
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset grid: side 100, 16 by 16 cells.
    opening = '{
      make_command(MODE_ENTER, 0, 500, 500, 100),
      make_command(MODE_ENTER, 1, 550, 500, 50),
      make_command(MODE_ENTER, 2, 600, 500, 0),
      make_command(MODE_ENTER, 3, 600, 500, 0),
      make_command(MODE_ENTER, 5, 680, 500, 10),
      make_command(MODE_ENTER, 63, 1599, 1599, 100),
      make_command(MODE_ENTER, 4, 0, 0, 100),
      make_command(MODE_ENTER, 6, 500, 500, 101),
      make_command(MODE_ENTER, 7, 100, 100, 65535),
      make_command(MODE_ENTER, 8, 1600, 10, 5),
      make_command(MODE_ENTER, 9, 10, 1600, 5),
      make_command(MODE_ENTER, 10, 65535, 65535, 100),
      make_command(MODE_NONE, 63, 65535, 65535, 65535),
      make_command(MODE_MOVE, 1, 640, 500, 0),
      make_command(MODE_MOVE, 11, 600, 500, 0),
      make_command(MODE_MOVE, 1, 1600, 0, 0),
      make_command(MODE_ENTER, 0, 520, 500, 80),
      make_command(MODE_MOVE, 63, 1599, 1500, 0),
      make_command(MODE_LEAVE, 0, 0, 0, 0),
      make_command(MODE_LEAVE, 0, 0, 0, 0),
      make_command(MODE_LEAVE, 12, 0, 0, 0),
      make_command(MODE_ENTER, 62, 1599, 1550, 100),
      make_command(MODE_NONE, 0, 0, 0, 0)
    };
    foreach (opening[k]) begin
      sender_gap();
      issue(opening[k]);
    end

    for (int p = 0; p < PHASES; p++) begin
      program_registers(phase_side[p], phase_rows[p], phase_cols[p]);
      steady = (p == PHASES - 1);
      aim_cluster();
      if (p == 0) begin
        // Pack every slot into one small patch, then re-enter one slot to draw a
        // notice from all 63 others.
        for (int k = 0; k < DEF_MAX_ENTITIES; k++) begin
          sender_gap();
          issue(make_command(MODE_ENTER, k, 30 + $urandom_range(0, 10),
                             30 + $urandom_range(0, 10), 20));
        end
        issue(make_command(MODE_ENTER, 0, 35, 35, 20));
      end
      for (int k = 0; k < phase_items[p]; k++) begin
        if ($urandom_range(0, 9) == 0) aim_cluster();
        sender_gap();
        issue(random_command());
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/aoi_pkg.sv
hdl/aoi_ram.sv
hdl/aoi_span.sv
hdl/aoi_sees.sv
hdl/area_of_interest_tracker_top.sv
bench/testbench.sv
